[src/pfci_pkg.sv]
// Shared types and constants of the polyphase coefficient interpolator.
`timescale 1ns / 1ps
package pfci_pkg;

  localparam int COEF_W  = 16;  // Q1.15 table entries and coefficients
  localparam int TAP_W   = 6;   // tap number
  localparam int HALF_W  = 6;   // tap_half_count register
  localparam int PHN_W   = 8;   // phase_count register
  localparam int PHASE_W = 16;  // Q0.16 phase
  localparam int LIDX_W  = 12;  // load_index field
  localparam int IDX_W   = 16;  // internal table index, covers depth and base math
  localparam int MUL_A_W = 18;  // signed multiplier operand
  localparam int MUL_B_W = 16;  // unsigned multiplier operand
  localparam int PROD_W  = 35;  // signed product, MUL_A_W + MUL_B_W + 1

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    CFG_TAP_HALF  = 1'b0,
    CFG_PHASE_CNT = 1'b1
  } cfg_reg_e;

  // operand selection of the shared multiplier
  typedef enum logic [1:0] {
    MUL_TAP   = 2'd0,
    MUL_PHASE = 2'd1,
    MUL_HALF  = 2'd2
  } mul_sel_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    logic     cap_frac;
  } dp_ctl_t;

  // one issued tap, travels alongside the table reads
  typedef struct packed {
    logic             valid;
    logic             hi;
    logic             last;
    logic [TAP_W-1:0] tap;
    logic             ok0;
    logic             ok1;
  } tap_tok_t;

endpackage

[src/pfci_table.sv]
// Prototype table: one write port, two registered read ports.
`timescale 1ns / 1ps
module pfci_table #(
  parameter int TABLE_DEPTH = 4096,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AW-1:0]                      waddr_i,
  input  logic signed [pfci_pkg::COEF_W-1:0] wdata_i,
  input  logic [AW-1:0]                      raddr0_i,
  input  logic [AW-1:0]                      raddr1_i,
  output logic signed [pfci_pkg::COEF_W-1:0] rdata0_o,
  output logic signed [pfci_pkg::COEF_W-1:0] rdata1_o
);
  import pfci_pkg::*;

  logic signed [COEF_W-1:0] mem_q [TABLE_DEPTH];
  logic signed [COEF_W-1:0] rdata0_q, rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

[src/pfci_datapath.sv]
// Shared multiplier, operand selection and round/saturate stage.
`timescale 1ns / 1ps
module pfci_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pfci_pkg::dp_ctl_t                  ctl_i,
  input  pfci_pkg::tap_tok_t                 tok_i,
  input  logic [pfci_pkg::PHN_W-1:0]         n_i,
  input  logic [pfci_pkg::HALF_W-1:0]        h_i,
  input  logic [pfci_pkg::PHASE_W-1:0]       phase_i,
  input  logic signed [pfci_pkg::COEF_W-1:0] rd0_i,
  input  logic signed [pfci_pkg::COEF_W-1:0] rd1_i,
  output logic signed [pfci_pkg::PROD_W-1:0] mul_res_o,
  output logic                               busy_o,
  output logic                               res_valid_o,
  output logic [pfci_pkg::TAP_W-1:0]         tap_o,
  output logic signed [pfci_pkg::COEF_W-1:0] coef_o,
  output logic                               last_o
);
  import pfci_pkg::*;

  localparam int RND_W = PROD_W - 16;

  tap_tok_t                 tok1_q, tok2_q;
  logic [MUL_B_W-1:0]       frac_q;
  logic signed [COEF_W-1:0] a_s, b_s, a2_q;
  logic signed [COEF_W:0]   diff_s;
  logic signed [MUL_A_W-1:0] op_a;
  logic [MUL_B_W-1:0]       op_b;
  logic signed [PROD_W-1:0] mul_q, sum_s;
  logic signed [RND_W-1:0]  rnd_s;
  logic signed [COEF_W-1:0] sat_s;
  logic                     res_valid_q, last_q;
  logic [TAP_W-1:0]         tap_q;
  logic signed [COEF_W-1:0] coef_q;

  // stage 1: pick a/b per half, masked entries read as zero
  always_comb begin
    if (tok1_q.hi) begin
      a_s = tok1_q.ok1 ? rd1_i : '0;
      b_s = tok1_q.ok0 ? rd0_i : '0;
    end else begin
      a_s = tok1_q.ok0 ? rd0_i : '0;
      b_s = tok1_q.ok1 ? rd1_i : '0;
    end
    diff_s = (COEF_W+1)'(b_s) - (COEF_W+1)'(a_s);
  end

  always_comb begin
    unique case (ctl_i.mul_sel)
      MUL_PHASE: begin
        op_a = MUL_A_W'(n_i);
        op_b = phase_i;
      end
      MUL_HALF: begin
        op_a = MUL_A_W'(h_i);
        op_b = MUL_B_W'(n_i);
      end
      default: begin
        op_a = MUL_A_W'(diff_s);
        op_b = frac_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= op_a * $signed({1'b0, op_b});
    a2_q  <= a_s;
    if (ctl_i.cap_frac) begin
      frac_q <= mul_q[MUL_B_W-1:0];
    end
  end

  // stage 2: a*2^16 + (b-a)*f + half, floor shift, saturate
  always_comb begin
    sum_s = (PROD_W'(a2_q) <<< 16) + mul_q + PROD_W'(32768);
    rnd_s = sum_s[PROD_W-1:16];
    priority if (rnd_s > RND_W'(32767)) begin
      sat_s = 16'sh7fff;
    end else if (rnd_s < -RND_W'(32768)) begin
      sat_s = 16'sh8000;
    end else begin
      sat_s = rnd_s[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok1_q      <= '0;
      tok2_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      tok1_q      <= tok_i;
      tok2_q      <= tok1_q;
      res_valid_q <= tok2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    tap_q  <= tok2_q.tap;
    last_q <= tok2_q.last;
    coef_q <= sat_s;
  end

  assign mul_res_o   = mul_q;
  assign busy_o      = tok1_q.valid | tok2_q.valid;
  assign res_valid_o = res_valid_q;
  assign tap_o       = tap_q;
  assign coef_o      = coef_q;
  assign last_o      = last_q;

endmodule

[src/pfci_sequencer.sv]
// Sequencer: setup multiplies, table address walk and tap tokens.
`timescale 1ns / 1ps
module pfci_sequencer #(
  parameter int TABLE_DEPTH = 4096,
  localparam int AW = $clog2(TABLE_DEPTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               go_i,
  input  logic [pfci_pkg::HALF_W-1:0]        h_i,
  input  logic [pfci_pkg::PHN_W-1:0]         n_i,
  input  logic signed [pfci_pkg::PROD_W-1:0] mul_res_i,
  output pfci_pkg::dp_ctl_t                  ctl_o,
  output pfci_pkg::tap_tok_t                 tok_o,
  output logic [AW-1:0]                      raddr0_o,
  output logic [AW-1:0]                      raddr1_o,
  output logic                               active_o
);
  import pfci_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MULP = 5'b00010,
    S_MULT = 5'b00100,
    S_BASE = 5'b01000,
    S_RUN  = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [TAP_W-1:0]   k_q, k_d;
  logic [PHN_W-1:0]   p_q, p_d;
  logic [IDX_W-1:0]   term_q, term_d;
  logic [IDX_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]   idx0, idx1;
  logic               in_hi, is_last;

  assign in_hi   = (k_q >= h_i);
  assign is_last = ({1'b0, k_q} == ({h_i, 1'b0} - 7'd1));
  assign idx0    = in_hi ? hi_q : lo_q;
  assign idx1    = idx0 + IDX_W'(1);

  always_comb begin
    state_d        = state_q;
    k_d            = k_q;
    p_d            = p_q;
    term_d         = term_q;
    lo_d           = lo_q;
    hi_d           = hi_q;
    ctl_o.mul_sel  = MUL_TAP;
    ctl_o.cap_frac = 1'b0;
    tok_o          = '0;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          state_d = S_MULP;
        end
      end
      S_MULP: begin
        ctl_o.mul_sel = MUL_PHASE;
        state_d       = S_MULT;
      end
      S_MULT: begin
        // product of phase and N is on the multiplier output now
        ctl_o.mul_sel  = MUL_HALF;
        ctl_o.cap_frac = 1'b1;
        p_d            = mul_res_i[16 +: PHN_W];
        state_d        = S_BASE;
      end
      S_BASE: begin
        term_d  = mul_res_i[IDX_W-1:0];
        lo_d    = IDX_W'(p_q) + mul_res_i[IDX_W-1:0] - IDX_W'(n_i);
        hi_d    = IDX_W'(n_i) - IDX_W'(1) - IDX_W'(p_q);
        k_d     = '0;
        state_d = (h_i == '0) ? S_IDLE : S_RUN;
      end
      S_RUN: begin
        tok_o.valid = 1'b1;
        tok_o.hi    = in_hi;
        tok_o.last  = is_last;
        tok_o.tap   = k_q;
        tok_o.ok0   = (idx0 != term_q) && (32'(idx0) < TABLE_DEPTH);
        tok_o.ok1   = (idx1 != term_q) && (32'(idx1) < TABLE_DEPTH);
        if (in_hi) begin
          hi_d = hi_q + IDX_W'(n_i);
        end else begin
          lo_d = lo_q - IDX_W'(n_i);
        end
        if (is_last) begin
          state_d = S_IDLE;
        end else begin
          k_d = k_q + TAP_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    term_q <= term_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
  end

  assign raddr0_o = idx0[AW-1:0];
  assign raddr1_o = idx1[AW-1:0];
  assign active_o = (state_q != S_IDLE);

endmodule

[src/polyphase_fir_coefficient_interpolator_core.sv]
// Top level of the polyphase FIR coefficient interpolator.
`timescale 1ns / 1ps
// Usage
//   Command channel: an item transfers at a rising edge with start high and
//   busy low. mode_i = 0 writes load_value_i to table entry load_index_i
//   (indexes at or beyond TABLE_DEPTH are dropped); mode_i = 1 computes the
//   2H taps for phase_i. Loads leave busy low.
//   Result channel: each tap is shown for exactly one cycle with
//   result_valid_o high, in ascending tap order, last_o on the final tap.
//   The receiver cannot stall; every strobed cycle is a transfer.
//   Config port: cfg_we_i writes cfg_data_i to register cfg_index_i
//   (0: tap_half_count, 1: phase_count); write only while idle, the block does not enforce this.
// Sequence
//   Setup states MULP, MULT and BASE run phase*N and H*N on the shared
//   multiplier, then one tap issues per cycle from the dual-read table;
//   a tap passes the table read, multiplier and output registers before
//   it leaves. Busy stays high until the last tap reaches the output
//   register, so no new command transfers while a compute command runs.
// Reset
//   Control state and the registers return to H = 8, N = 32. The table is not
//   cleared; entries must be loaded before use.
module polyphase_fir_coefficient_interpolator_core #(
  parameter int TABLE_DEPTH   = 4096,
  parameter int MAX_HALF_TAPS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic                                mode_i,
  input  logic [pfci_pkg::LIDX_W-1:0]         load_index_i,
  input  logic signed [pfci_pkg::COEF_W-1:0]  load_value_i,
  input  logic [pfci_pkg::PHASE_W-1:0]        phase_i,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [0:0]                          cfg_index_i,
  input  logic [pfci_pkg::PHN_W-1:0]          cfg_data_i,
  // results
  output logic                                result_valid_o,
  output logic [pfci_pkg::TAP_W-1:0]          tap_index_o,
  output logic signed [pfci_pkg::COEF_W-1:0]  coefficient_o,
  output logic                                last_o
);
  import pfci_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  logic [HALF_W-1:0]        half_q;
  logic [PHN_W-1:0]         phn_q;
  logic [HALF_W-1:0]        h_eff;
  logic [PHN_W-1:0]         n_eff;
  logic [PHASE_W-1:0]       phase_q;
  logic                     accept, go;
  logic [IDX_W-1:0]         wr_idx;
  logic                     tbl_we;
  logic [AW-1:0]            raddr0, raddr1;
  logic signed [COEF_W-1:0] rd0, rd1;
  logic signed [PROD_W-1:0] mul_res;
  dp_ctl_t                  ctl;
  tap_tok_t                 tok;
  logic                     seq_active, dp_busy;

  assign accept = start & ~busy;
  assign go     = accept & mode_i;
  assign busy   = seq_active | dp_busy;

  // effective H and N: clamp H, N of zero acts as one
  assign h_eff = (half_q > HALF_W'(MAX_HALF_TAPS)) ? HALF_W'(MAX_HALF_TAPS) : half_q;
  assign n_eff = (phn_q == '0) ? PHN_W'(1) : phn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HALF_W'(8);
      phn_q  <= PHN_W'(32);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TAP_HALF:  half_q <= cfg_data_i[HALF_W-1:0];
        CFG_PHASE_CNT: phn_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      phase_q <= phase_i;
    end
  end

  // table writes go straight in on a load transfer
  assign wr_idx = IDX_W'(load_index_i);
  assign tbl_we = accept & ~mode_i & (32'(wr_idx) < TABLE_DEPTH);

  pfci_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (wr_idx[AW-1:0]),
    .wdata_i (load_value_i),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(rd0),
    .rdata1_o(rd1)
  );

  pfci_sequencer #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .h_i      (h_eff),
    .n_i      (n_eff),
    .mul_res_i(mul_res),
    .ctl_o    (ctl),
    .tok_o    (tok),
    .raddr0_o (raddr0),
    .raddr1_o (raddr1),
    .active_o (seq_active)
  );

  pfci_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .tok_i      (tok),
    .n_i        (n_eff),
    .h_i        (h_eff),
    .phase_i    (phase_q),
    .rd0_i      (rd0),
    .rd1_i      (rd1),
    .mul_res_o  (mul_res),
    .busy_o     (dp_busy),
    .res_valid_o(result_valid_o),
    .tap_o      (tap_index_o),
    .coef_o     (coefficient_o),
    .last_o     (last_o)
  );

  // a result always belongs to a command still in flight
  a_result_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe outside a running command");

  // taps of one run come back to back, and a run ends with a gap
  a_taps_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |=> result_valid_o)
    else $error("gap inside a tap run");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("tap right after last tap");

  // tap numbers count up by one within a run
  a_tap_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (tap_index_o != '0)) |->
      ($past(result_valid_o) && (tap_index_o == $past(tap_index_o) + TAP_W'(1))))
    else $error("tap index out of order");

endmodule

[tb/polyphase_fir_coefficient_interpolator_core_tb.sv]
// Self-checking testbench for the polyphase FIR coefficient interpolator core.
`timescale 1ns / 1ps
module polyphase_fir_coefficient_interpolator_core_tb;
  import pfci_pkg::*;

  localparam int          TBL_DEPTH  = 4096;
  localparam int          MAX_HALF   = 32;
  localparam int          SETTLE     = 10;
  localparam int unsigned LIMIT      = 250_000;  // several times the slowest clean run
  localparam int          MAX_PRINTS = 50;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_COMPUTE = 1'b1
  } cmd_mode_e;

  // one expected tap on the result port
  typedef struct packed {
    logic [TAP_W-1:0]         tap;
    logic signed [COEF_W-1:0] coef;
    logic                     last;
  } tap_exp_t;

  // Mirror of the prototype table and the two registers. Every accepted command
  // is noted here; a compute command queues its whole tap run at once.
  class tap_checker;
    logic [COEF_W-1:0] proto_mem [TBL_DEPTH];
    int unsigned       half_reg;
    int unsigned       phase_reg;
    tap_exp_t          due_taps [$];
    int                errors;
    int                taps_seen;

    function new();
      half_reg  = 8;
      phase_reg = 32;
      errors    = 0;
      taps_seen = 0;
      foreach (proto_mem[i]) proto_mem[i] = '0;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    endfunction

    function int pending_count();
      return due_taps.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [PHN_W-1:0] data);
      if (idx == CFG_TAP_HALF) half_reg = data[HALF_W-1:0];
      else phase_reg = data;
    endfunction

    // terminal entry and anything past the table read as zero
    function longint fetch(int unsigned idx, int unsigned terminal);
      if (idx == terminal || idx >= TBL_DEPTH) return 0;
      return longint'($signed(proto_mem[idx]));
    endfunction

    // rounded linear blend, floor shift, then clamp to Q1.15
    function logic signed [COEF_W-1:0] blend(longint a, longint b, int unsigned f);
      longint acc;
      acc = a * (65536 - longint'(f)) + b * longint'(f) + 32768;
      acc = acc >>> 16;
      if (acc > 32767) acc = 32767;
      else if (acc < -32768) acc = -32768;
      return acc[COEF_W-1:0];
    endfunction

    function void note_command(cmd_mode_e mode, logic [LIDX_W-1:0] lidx,
                               logic [COEF_W-1:0] lval, logic [PHASE_W-1:0] phase);
      int unsigned h, n, terminal, prod, p, f, base, k;
      longint      a, b;
      tap_exp_t    t;
      if (mode == MODE_LOAD) begin
        if (lidx < TBL_DEPTH) proto_mem[lidx] = lval;
        return;
      end
      h        = (half_reg > MAX_HALF) ? MAX_HALF : half_reg;
      n        = (phase_reg == 0) ? 1 : phase_reg;
      terminal = n * h;
      prod     = phase * n;
      p        = prod >> 16;
      f        = prod & 32'hFFFF;
      for (k = 0; k < 2 * h; k++) begin
        if (k < h) begin
          base = p + (h - 1 - k) * n;
          a    = fetch(base, terminal);
          b    = fetch(base + 1, terminal);
        end else begin
          base = (n - 1 - p) + (k - h) * n;
          a    = fetch(base + 1, terminal);
          b    = fetch(base, terminal);
        end
        t.tap  = TAP_W'(k);
        t.coef = blend(a, b, f);
        t.last = (k == 2 * h - 1);
        due_taps.push_back(t);
      end
    endfunction

    function void check_tap(logic [TAP_W-1:0] tap, logic signed [COEF_W-1:0] coef,
                            logic last);
      tap_exp_t t;
      taps_seen++;
      if (due_taps.size() == 0) begin
        report($sformatf("unexpected tap %0d coef %0d last %b", tap, coef, last));
        return;
      end
      t = due_taps.pop_front();
      if (tap !== t.tap)
        report($sformatf("tap index %0d, want %0d", tap, t.tap));
      if (coef !== t.coef)
        report($sformatf("tap %0d coef %0d, want %0d", t.tap, coef, t.coef));
      if (last !== t.last)
        report($sformatf("tap %0d last %b, want %b", t.tap, last, t.last));
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start;
  logic                     busy;
  logic                     mode_i;
  logic [LIDX_W-1:0]        load_index_i;
  logic signed [COEF_W-1:0] load_value_i;
  logic [PHASE_W-1:0]       phase_i;
  logic                     cfg_we_i;
  logic [0:0]               cfg_index_i;
  logic [PHN_W-1:0]         cfg_data_i;
  logic                     result_valid_o;
  logic [TAP_W-1:0]         tap_index_o;
  logic signed [COEF_W-1:0] coefficient_o;
  logic                     last_o;

  tap_checker  sb = new();
  bit          loaded [TBL_DEPTH];  // entries written so far; unwritten ones are never read
  bit          idle_enable;
  int unsigned cycles;
  int          n_load, n_compute, n_cfg;

  polyphase_fir_coefficient_interpolator_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .mode_i        (mode_i),
    .load_index_i  (load_index_i),
    .load_value_i  (load_value_i),
    .phase_i       (phase_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .tap_index_o   (tap_index_o),
    .coefficient_o (coefficient_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: the receiver never stalls, so every strobed cycle is a transfer.
  // Outputs are sampled at the rising edge, before the block updates them.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o !== 1'b0)
      sb.check_tap(tap_index_o, coefficient_o, last_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d taps still due", cycles, sb.pending_count());
      $display("polyphase_fir_coefficient_interpolator_core_tb: errors");
      $finish;
    end
  end

  // Drives one command and returns at the edge where it transfers. Start is left
  // high so a following command goes out back to back; callers that stop
  // sending lower it at the next falling edge.
  task automatic send_item(cmd_mode_e mode, logic [LIDX_W-1:0] lidx,
                           logic [COEF_W-1:0] lval, logic [PHASE_W-1:0] ph);
    @(negedge clk_i);
    while (idle_enable && $urandom_range(99) < 9) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start        = 1'b1;
    mode_i       = mode;
    load_index_i = lidx;
    load_value_i = lval;
    phase_i      = ph;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_command(mode, lidx, lval, ph);
    if (mode == MODE_LOAD) begin
      loaded[lidx] = 1'b1;
      n_load++;
    end else begin
      n_compute++;
    end
  endtask

  // unused fields carry random bits so every input bit toggles
  task automatic send_load(logic [LIDX_W-1:0] lidx, logic [COEF_W-1:0] lval);
    send_item(MODE_LOAD, lidx, lval, PHASE_W'($urandom));
  endtask

  task automatic send_compute(logic [PHASE_W-1:0] ph);
    send_item(MODE_COMPUTE, LIDX_W'($urandom), COEF_W'($urandom), ph);
  endtask

  // Stop sending, wait for every due tap, then give the block time to finish a
  // command that makes no taps (zero half length) before touching registers.
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // only called after drain(), so the block is idle
  task automatic write_reg(cfg_reg_e idx, logic [PHN_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    sb.write_reg(idx, data);
    n_cfg++;
  endtask

  // table values lean on the Q1.15 extremes
  function automatic logic [COEF_W-1:0] pick_value();
    unique case ($urandom_range(7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Load the still unwritten entries that a phase command reads under the
  // current registers; the terminal entry and indexes past the table are left.
  task automatic load_for(logic [PHASE_W-1:0] ph);
    int unsigned h, n, terminal, p, i;
    int unsigned idx [4];
    h        = (sb.half_reg > MAX_HALF) ? MAX_HALF : sb.half_reg;
    n        = (sb.phase_reg == 0) ? 1 : sb.phase_reg;
    terminal = n * h;
    p        = (ph * n) >> 16;
    for (i = 0; i < h; i++) begin
      idx[0] = p + i * n;
      idx[1] = idx[0] + 1;
      idx[2] = (n - 1 - p) + i * n;
      idx[3] = idx[2] + 1;
      foreach (idx[j])
        if (idx[j] < TBL_DEPTH && idx[j] != terminal && !loaded[idx[j]])
          send_load(LIDX_W'(idx[j]), pick_value());
    end
  endtask

  task automatic send_phase(logic [PHASE_W-1:0] ph);
    load_for(ph);
    send_compute(ph);
  endtask

  // half length: mostly short, sometimes zero or long (9 to 63, past saturation above 32);
  // the two bits above the register get random values
  function automatic logic [PHN_W-1:0] pick_half();
    int unsigned r;
    logic [HALF_W-1:0] h;
    r = $urandom_range(9);
    if (r == 0) h = '0;
    else if (r <= 6) h = HALF_W'($urandom_range(8, 1));
    else h = HALF_W'($urandom_range(63, 9));
    return {2'($urandom), h};
  endfunction

  // phase count for a given half length, kept so N*H stays within 64 entries
  function automatic logic [PHN_W-1:0] pick_phases(logic [PHN_W-1:0] half);
    int unsigned h, top;
    h = half[HALF_W-1:0];
    if (h > MAX_HALF) h = MAX_HALF;
    top = (h == 0) ? 255 : 64 / h;
    unique case ($urandom_range(5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return PHN_W'(top);
      default: return PHN_W'($urandom_range(top, 1));
    endcase
  endfunction

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    mode_i       = MODE_LOAD;
    load_index_i = '0;
    load_value_i = '0;
    phase_i      = '0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = CFG_TAP_HALF;
    cfg_data_i   = '0;
    idle_enable  = 1'b1;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed ---
    // reset registers (H = 8, N = 32): a nonzero value on the terminal entry,
    // which must still read as zero, and one on the top index
    send_load(LIDX_W'(256), 16'h7FFF);
    send_load(LIDX_W'(TBL_DEPTH - 1), 16'h8000);
    send_phase(16'h0000);
    send_phase(16'hFFFF);
    send_phase(16'h8000);
    send_phase(16'h0001);
    send_phase(16'h7FFF);

    // smallest filter: one phase, two taps
    drain();
    write_reg(CFG_TAP_HALF, 8'd1);
    write_reg(CFG_PHASE_CNT, 8'd1);
    send_phase(16'h0000);
    send_phase(16'hFFFF);

    // zero half length makes no taps; a load right behind it still transfers
    drain();
    write_reg(CFG_TAP_HALF, 8'd0);
    send_phase(16'h1234);
    send_load(LIDX_W'(1), 16'h4000);

    // zero phase count behaves as one
    drain();
    write_reg(CFG_TAP_HALF, 8'd2);
    write_reg(CFG_PHASE_CNT, 8'd0);
    send_phase(16'hA5A5);

    // all-ones write: H reads back as 63 and saturates to 32
    drain();
    write_reg(CFG_TAP_HALF, 8'hFF);
    write_reg(CFG_PHASE_CNT, 8'd1);
    send_phase(16'h0000);
    send_phase(16'hFFFF);
    send_phase(16'h5555);

    // N = 255 pushes reads past the end of the table
    drain();
    write_reg(CFG_PHASE_CNT, 8'd255);
    send_phase(16'hFFFF);
    send_phase(16'h0100);

    // --- random --- small filters, every entry read gets loaded first
    for (int blk = 0; blk < 11; blk++) begin
      logic [PHN_W-1:0]   half_sel;
      logic [PHASE_W-1:0] ph;
      drain();
      half_sel = pick_half();
      write_reg(CFG_TAP_HALF, half_sel);
      write_reg(CFG_PHASE_CNT, pick_phases(half_sel));
      idle_enable = !(blk >= 4 && blk <= 6);  // back-to-back stretch
      repeat (10) begin
        if ($urandom_range(99) < 4) drain();  // sender holds off until all taps are in
        if ($urandom_range(99) < 30) begin
          send_load(LIDX_W'($urandom), pick_value());
        end else begin
          ph = PHASE_W'($urandom);
          send_phase(ph);
        end
      end
    end

    drain();
    repeat (2 * SETTLE) @(posedge clk_i);
    $display("run covered %0d table loads, %0d phase commands, %0d register writes",
             n_load, n_compute, n_cfg);
    $display("%0d taps checked, %0d mismatches", sb.taps_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("polyphase_fir_coefficient_interpolator_core_tb: clean");
    end else begin
      if (sb.pending_count() != 0)
        $display("%0d taps never arrived", sb.pending_count());
      $display("polyphase_fir_coefficient_interpolator_core_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
src/pfci_pkg.sv
src/pfci_table.sv
src/pfci_datapath.sv
src/pfci_sequencer.sv
src/polyphase_fir_coefficient_interpolator_core.sv
tb/polyphase_fir_coefficient_interpolator_core_tb.sv
